@@ hw/rtl/scdt_pkg.sv @@
// shared types, constants and helper functions of the servo command unit
`timescale 1ns / 1ps
`default_nettype none

package scdt_pkg;

  localparam int ID_W   = 4;
  localparam int POS_W  = 10;
  localparam int TGT_W  = 16;
  localparam int TS_W   = 32;
  localparam int TIME_W = 10;

  // register indexes on the configuration port
  localparam logic REG_DEADZONE = 1'b0;
  localparam logic REG_CENTER   = 1'b1;

  localparam logic [POS_W-1:0] DEADZONE_RESET = 10'd5;
  localparam logic [POS_W-1:0] CENTER_RESET   = 10'd500;

  // distance thresholds and move durations
  localparam logic [POS_W-1:0]  DIST_SHORT = 10'd50;
  localparam logic [POS_W-1:0]  DIST_MID   = 10'd200;
  localparam logic [POS_W-1:0]  DIST_FAR   = 10'd300;
  localparam logic [TIME_W-1:0] TIME_SHORT = 10'd1;
  localparam logic [TIME_W-1:0] TIME_MID   = 10'd300;
  localparam logic [TIME_W-1:0] TIME_LONG  = 10'd600;
  localparam logic [TIME_W-1:0] TIME_FAR   = 10'd800;

  localparam logic [TS_W-1:0] MOVE_SETTLE  = 32'd50;
  localparam logic [TS_W-1:0] RESET_SETTLE = 32'd100;

  localparam int QUEUE_DEPTH = 2;

  // command kinds
  localparam logic KIND_MOVE  = 1'b0;
  localparam logic KIND_RESET = 1'b1;

  // classified command handed from the front to the back
  typedef struct packed {
    logic              kind;
    logic [ID_W-1:0]   id;
    logic [POS_W-1:0]  pos;
    logic [TS_W-1:0]   now;
    logic              recording;
  } cmd_t;

  function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                input logic [POS_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [TIME_W-1:0] time_for(input logic [POS_W-1:0] gap);
    if (gap < DIST_SHORT) begin
      time_for = TIME_SHORT;
    end else if (gap < DIST_MID) begin
      time_for = TIME_MID;
    end else begin
      time_for = TIME_LONG;
    end
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/scdt_in_if.sv @@
// input channel carrying one servo command item
`timescale 1ns / 1ps
`default_nettype none

interface scdt_in_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [scdt_pkg::ID_W-1:0]  servo_id;
  logic signed [scdt_pkg::TGT_W-1:0] target;
  logic [scdt_pkg::TS_W-1:0]  now_ms;
  logic                      playing;
  logic                      recording;

  modport source (output valid, kind, servo_id, target, now_ms, playing, recording,
                  input ready);
  modport sink (input valid, kind, servo_id, target, now_ms, playing, recording,
                output ready);
endinterface

`default_nettype wire

@@ hw/rtl/scdt_out_if.sv @@
// output channel carrying one servo command result
`timescale 1ns / 1ps
`default_nettype none

interface scdt_out_if;
  logic                         valid;
  logic                         ready;
  logic [scdt_pkg::ID_W-1:0]    out_id;
  logic [scdt_pkg::POS_W-1:0]   out_position;
  logic [scdt_pkg::TIME_W-1:0]  move_time;
  logic [scdt_pkg::TS_W-1:0]    end_time;
  logic                         record;
  logic                         last;

  modport source (output valid, out_id, out_position, move_time, end_time, record, last,
                  input ready);
  modport sink (input valid, out_id, out_position, move_time, end_time, record, last,
                output ready);
endinterface

`default_nettype wire

@@ hw/rtl/scdt_front.sv @@
// front end: accepts items, drops the ones that can never act, clamps targets
`timescale 1ns / 1ps
`default_nettype none

module scdt_front #(
  parameter int NUM_SERVOS   = 8,
  parameter int MAX_POSITION = 1000
) (
  scdt_in_if.sink          cmd,
  input  wire logic        q_full,
  output logic             push,
  output scdt_pkg::cmd_t   push_cmd
);

  logic                          id_ok;
  logic                          keep;
  logic [scdt_pkg::POS_W-1:0]    pos;

  assign cmd.ready = !q_full;

  assign id_ok = (cmd.servo_id != '0) &&
                 ({1'b0, cmd.servo_id} <= (scdt_pkg::ID_W+1)'(NUM_SERVOS));

  // reset items go through even while playing
  assign keep = (cmd.kind == scdt_pkg::KIND_RESET) || (!cmd.playing && id_ok);

  always_comb begin
    if (cmd.target[scdt_pkg::TGT_W-1]) begin
      pos = '0;
    end else if (cmd.target > scdt_pkg::TGT_W'(MAX_POSITION)) begin
      pos = scdt_pkg::POS_W'(MAX_POSITION);
    end else begin
      pos = cmd.target[scdt_pkg::POS_W-1:0];
    end
  end

  assign push = cmd.valid && !q_full && keep;

  always_comb begin
    push_cmd.kind      = cmd.kind;
    push_cmd.id        = cmd.servo_id;
    push_cmd.pos       = pos;
    push_cmd.now       = cmd.now_ms;
    push_cmd.recording = cmd.recording;
  end

endmodule

`default_nettype wire

@@ hw/rtl/scdt_queue.sv @@
// short command queue between the front and the back
`timescale 1ns / 1ps
`default_nettype none

module scdt_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  scdt_pkg::cmd_t       push_cmd,
  output logic                 full,
  output logic                 head_valid,
  input  wire logic            pop,
  output scdt_pkg::cmd_t       head_cmd
);

  localparam int PW = (scdt_pkg::QUEUE_DEPTH > 1) ? $clog2(scdt_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(scdt_pkg::QUEUE_DEPTH + 1);

  scdt_pkg::cmd_t  entries [scdt_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full       = (count == CW'(scdt_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(scdt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(scdt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/scdt_back.sv @@
// back end: holds servo positions, applies the deadzone and emits commands
`timescale 1ns / 1ps
`default_nettype none

module scdt_back #(
  parameter int NUM_SERVOS   = 8,
  parameter int MAX_POSITION = 1000
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [scdt_pkg::POS_W-1:0]  deadzone,
  input  wire logic [scdt_pkg::POS_W-1:0]  center_cfg,
  input  wire logic                        head_valid,
  input  scdt_pkg::cmd_t                   head_cmd,
  output logic                             pop,
  scdt_out_if.source                       res
);

  localparam int IW = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
  localparam logic [scdt_pkg::POS_W-1:0] MAX_POS = scdt_pkg::POS_W'(MAX_POSITION);
  localparam logic [scdt_pkg::POS_W-1:0] START_POS =
    (scdt_pkg::CENTER_RESET > MAX_POS) ? MAX_POS : scdt_pkg::CENTER_RESET;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MOVE = 4'b0010,
    S_SCAN = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t                          state;
  scdt_pkg::cmd_t                  cur;
  logic [scdt_pkg::POS_W-1:0]      stored [NUM_SERVOS];
  logic [IW-1:0]                   cnt;
  logic [scdt_pkg::POS_W-1:0]      max_dist;

  logic                            out_vld;
  logic [scdt_pkg::ID_W-1:0]       o_id;
  logic [scdt_pkg::POS_W-1:0]      o_pos;
  logic [scdt_pkg::TIME_W-1:0]     o_time;
  logic [scdt_pkg::TS_W-1:0]       o_end;
  logic                            o_rec;
  logic                            o_last;

  logic [scdt_pkg::POS_W-1:0]      center;
  logic [IW-1:0]                   mv_idx;
  logic [scdt_pkg::ID_W-1:0]       id_minus1;
  logic [scdt_pkg::POS_W-1:0]      mv_dist;
  logic [scdt_pkg::TIME_W-1:0]     mv_time;
  logic [scdt_pkg::POS_W-1:0]      scan_dist;
  logic [scdt_pkg::TIME_W-1:0]     rs_time;
  logic                            out_free;
  logic                            cnt_last;
  logic                            emit;

  assign center    = (center_cfg > MAX_POS) ? MAX_POS : center_cfg;
  assign id_minus1 = cur.id - 1'b1;
  assign mv_idx    = id_minus1[IW-1:0];
  assign mv_dist   = scdt_pkg::abs_diff(cur.pos, stored[mv_idx]);
  assign scan_dist = scdt_pkg::abs_diff(center, stored[cnt]);
  assign rs_time   = scdt_pkg::time_for(max_dist);
  assign out_free  = !out_vld || res.ready;
  assign cnt_last  = (cnt == IW'(NUM_SERVOS - 1));
  assign pop       = (state == S_IDLE) && head_valid;
  assign emit      = out_free && (((state == S_MOVE) && (mv_dist > deadzone)) ||
                                  (state == S_EMIT));

  // far moves get a minimum duration, reset does not
  always_comb begin
    mv_time = scdt_pkg::time_for(mv_dist);
    if (mv_dist > scdt_pkg::DIST_FAR && mv_time < scdt_pkg::TIME_FAR) begin
      mv_time = scdt_pkg::TIME_FAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      out_vld <= 1'b0;
      cnt     <= '0;
      for (int i = 0; i < NUM_SERVOS; i++) begin
        stored[i] <= START_POS;
      end
    end else begin
      if (emit) begin
        out_vld <= 1'b1;
      end else if (res.ready) begin
        out_vld <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (head_valid) begin
            cur      <= head_cmd;
            cnt      <= '0;
            max_dist <= '0;
            state    <= (head_cmd.kind == scdt_pkg::KIND_RESET) ? S_SCAN : S_MOVE;
          end
        end
        S_MOVE: begin
          if (mv_dist <= deadzone) begin
            state <= S_IDLE;
          end else if (out_free) begin
            o_id           <= cur.id;
            o_pos          <= cur.pos;
            o_time         <= mv_time;
            o_end          <= cur.now + scdt_pkg::TS_W'(mv_time) + scdt_pkg::MOVE_SETTLE;
            o_rec          <= cur.recording;
            o_last         <= 1'b1;
            stored[mv_idx] <= cur.pos;
            state          <= S_IDLE;
          end
        end
        S_SCAN: begin
          // one servo per cycle for the largest distance to center
          if (scan_dist > max_dist) begin
            max_dist <= scan_dist;
          end
          if (cnt_last) begin
            cnt   <= '0;
            state <= S_EMIT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            o_id        <= scdt_pkg::ID_W'({1'b0, cnt} + 1'b1);
            o_pos       <= center;
            o_time      <= rs_time;
            o_end       <= cur.now + scdt_pkg::TS_W'(rs_time) + scdt_pkg::RESET_SETTLE;
            o_rec       <= cnt_last ? cur.recording : 1'b0;
            o_last      <= cnt_last;
            stored[cnt] <= center;
            if (cnt_last) begin
              state <= S_IDLE;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid        = out_vld;
  assign res.out_id       = o_id;
  assign res.out_position = o_pos;
  assign res.move_time    = o_time;
  assign res.end_time     = o_end;
  assign res.record       = o_rec;
  assign res.last         = o_last;

endmodule

`default_nettype wire

@@ hw/rtl/servo_command_deadzone_timer_unit.sv @@
// top level of the servo command conditioner with its configuration registers
//
// Items enter on cmd (valid/ready). A move item names a servo and a target;
// a reset item sends every servo to the center position. Results leave on res
// (valid/ready), each one command for one servo, with last set on the final
// result of an item. Moves that are played back, address no servo or stay
// within the deadzone give no result.
// The front classifies and clamps in the accept cycle and pushes into a
// two-entry queue, so cmd.ready only drops when the queue is full.
// The back takes a queued move in its idle state and evaluates it in the
// move state that follows, so it takes no new item until the move is done;
// the result is registered. A reset scans the stored positions one servo a
// cycle, then emits one result a cycle while the output register is free.
// Results sit in an output register; while res.ready is low the back holds
// its work and the queue keeps taking items until it is full.
// Synchronous reset empties the queue, drops any pending result, sets the
// registers to deadzone 5 and center 500 and every stored position to center.
// Registers: deadzone at byte address 0, center at 4 (APB, no wait).
`timescale 1ns / 1ps
`default_nettype none

module servo_command_deadzone_timer_unit #(
  parameter int NUM_SERVOS   = 8,
  parameter int MAX_POSITION = 1000
) (
  input  wire logic         clk,
  input  wire logic         rst,
  scdt_in_if.sink           cmd,
  scdt_out_if.source        res,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [scdt_pkg::POS_W-1:0] deadzone;
  logic [scdt_pkg::POS_W-1:0] center_cfg;
  logic                       push;
  scdt_pkg::cmd_t             push_cmd;
  logic                       q_full;
  logic                       head_valid;
  logic                       pop;
  scdt_pkg::cmd_t             head_cmd;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone   <= scdt_pkg::DEADZONE_RESET;
      center_cfg <= scdt_pkg::CENTER_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        scdt_pkg::REG_DEADZONE: deadzone   <= pwdata[scdt_pkg::POS_W-1:0];
        scdt_pkg::REG_CENTER:   center_cfg <= pwdata[scdt_pkg::POS_W-1:0];
        default:                deadzone   <= deadzone;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      scdt_pkg::REG_DEADZONE: prdata = 32'(deadzone);
      scdt_pkg::REG_CENTER:   prdata = 32'(center_cfg);
      default:                prdata = '0;
    endcase
  end

  scdt_front #(
    .NUM_SERVOS   (NUM_SERVOS),
    .MAX_POSITION (MAX_POSITION)
  ) u_front (
    .cmd      (cmd),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  scdt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .pop        (pop),
    .head_cmd   (head_cmd)
  );

  scdt_back #(
    .NUM_SERVOS   (NUM_SERVOS),
    .MAX_POSITION (MAX_POSITION)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .deadzone   (deadzone),
    .center_cfg (center_cfg),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .res        (res)
  );

endmodule

`default_nettype wire
